// ===== rtl/lsf_pkg.sv =====
// Shared types, constants and helpers for the learning switch forwarder.
// No dependencies; every file of the block but lsf_ram imports this package.
package lsf_pkg;

    localparam int TABLE_DEPTH   = 64;
    localparam int NUM_PORTS     = 8;
    localparam int IDX_W         = $clog2(TABLE_DEPTH);
    localparam int MAC_W         = 48;
    localparam int PORT_W        = $clog2(NUM_PORTS);
    localparam int LEN_W         = 16;
    localparam int ACT_W         = 4;
    localparam int MASK_W        = NUM_PORTS;
    localparam int MAC_BYTES     = 6;
    localparam int GROUP_BIT_POS = 8 * (MAC_BYTES - 1);

    localparam logic [LEN_W-1:0] MIN_HEADER_BYTES = LEN_W'(14);
    localparam logic [ACT_W-1:0] ACTIVE_RESET     = ACT_W'(8);
    localparam logic [ACT_W-1:0] MAX_PORTS        = ACT_W'(NUM_PORTS);

    typedef enum logic [1:0] {
        ST_FWD      = 2'd0,
        ST_SHORT    = 2'd1,
        ST_SAME     = 2'd2,
        ST_BAD_PORT = 2'd3
    } t_status;

    typedef struct packed {
        logic [MAC_W-1:0]  mac;
        logic [PORT_W-1:0] port;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Scan request from the control logic to the table.
    typedef struct packed {
        logic             start;
        logic [MAC_W-1:0] src_mac;
        logic [MAC_W-1:0] dst_mac;
    } t_scan_cmd;

    // Scan outcome; hit fields are stable once done has pulsed.
    typedef struct packed {
        logic              done;
        logic              src_hit;
        logic [IDX_W-1:0]  src_idx;
        logic              dst_hit;
        logic [IDX_W-1:0]  dst_idx;
        logic [PORT_W-1:0] dst_port;
    } t_scan_res;

    // Learning write into the table.
    typedef struct packed {
        logic              en;
        logic              set_valid;
        logic [IDX_W-1:0]  idx;
        logic [MAC_W-1:0]  mac;
        logic [PORT_W-1:0] port;
    } t_tbl_wr;

    // Active port count clamped to 1 .. NUM_PORTS.
    function automatic logic [ACT_W-1:0] port_count(input logic [ACT_W-1:0] active);
        logic [ACT_W-1:0] n;
        n = active;
        if (n == '0) begin
            n = ACT_W'(1);
        end
        if (n > MAX_PORTS) begin
            n = MAX_PORTS;
        end
        return n;
    endfunction

endpackage

// ===== rtl/lsf_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module lsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/lsf_table.sv =====
// MAC table: entry RAM, per-entry valid bits, replace pointer and the scan engine.
// Depends on lsf_pkg and lsf_ram.
module lsf_table
    import lsf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_scan_cmd i_cmd,
    input  t_tbl_wr   i_wr,
    output t_scan_res o_res,
    output logic [IDX_W-1:0] o_replace_ptr
);

    logic                 r_valid [TABLE_DEPTH];
    logic [IDX_W-1:0]     r_ptr;
    logic                 r_scan_act;
    logic [IDX_W-1:0]     r_addr;
    logic                 r_rd_vld;
    logic                 r_rd_last;
    logic [IDX_W-1:0]     r_rd_idx;
    logic                 r_rd_ent_vld;
    logic                 r_done;
    logic                 r_src_hit;
    logic [IDX_W-1:0]     r_src_idx;
    logic                 r_dst_hit;
    logic [IDX_W-1:0]     r_dst_idx;
    logic [PORT_W-1:0]    r_dst_port;
    logic [ENTRY_W-1:0]   rd_data;
    t_entry               rd_entry;
    t_entry               wr_entry;
    logic                 addr_last;
    logic                 src_match;
    logic                 dst_match;

    assign wr_entry.mac  = i_wr.mac;
    assign wr_entry.port = i_wr.port;
    assign rd_entry      = t_entry'(rd_data);
    assign addr_last     = (r_addr == IDX_W'(TABLE_DEPTH - 1));

    lsf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_wr.en),
        .i_wr_addr (i_wr.idx),
        .i_wr_data (wr_entry),
        .i_rd_en   (r_scan_act),
        .i_rd_addr (r_addr),
        .o_rd_data (rd_data)
    );

    // Entries that were never written are masked by their valid bit.
    assign src_match = r_rd_vld && r_rd_ent_vld && (rd_entry.mac == i_cmd.src_mac);
    assign dst_match = r_rd_vld && r_rd_ent_vld && (rd_entry.mac == i_cmd.dst_mac);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                r_valid[i] <= 1'b0;
            end
            r_ptr      <= '0;
            r_scan_act <= 1'b0;
            r_addr     <= '0;
            r_rd_vld   <= 1'b0;
            r_rd_last  <= 1'b0;
            r_done     <= 1'b0;
            r_src_hit  <= 1'b0;
            r_dst_hit  <= 1'b0;
        end else begin
            if (i_wr.en && i_wr.set_valid) begin
                r_valid[i_wr.idx] <= 1'b1;
                r_ptr <= (r_ptr == IDX_W'(TABLE_DEPTH - 1)) ? '0 : r_ptr + 1'b1;
            end

            if (i_cmd.start) begin
                r_scan_act <= 1'b1;
                r_addr     <= '0;
            end else if (r_scan_act) begin
                r_addr <= r_addr + 1'b1;
                if (addr_last) begin
                    r_scan_act <= 1'b0;
                end
            end

            r_rd_vld  <= r_scan_act;
            r_rd_last <= r_scan_act && addr_last;
            r_done    <= r_rd_vld && r_rd_last;

            if (i_cmd.start) begin
                r_src_hit <= 1'b0;
                r_dst_hit <= 1'b0;
            end else begin
                if (src_match && !r_src_hit) begin
                    r_src_hit <= 1'b1;
                end
                if (dst_match && !r_dst_hit) begin
                    r_dst_hit <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx     <= r_addr;
        r_rd_ent_vld <= r_valid[r_addr];
        if (src_match && !r_src_hit) begin
            r_src_idx <= r_rd_idx;
        end
        if (dst_match && !r_dst_hit) begin
            r_dst_idx  <= r_rd_idx;
            r_dst_port <= rd_entry.port;
        end
    end

    assign o_res.done     = r_done;
    assign o_res.src_hit  = r_src_hit;
    assign o_res.src_idx  = r_src_idx;
    assign o_res.dst_hit  = r_dst_hit;
    assign o_res.dst_idx  = r_dst_idx;
    assign o_res.dst_port = r_dst_port;
    assign o_replace_ptr  = r_ptr;

endmodule

// ===== rtl/learning_switch_forwarder.sv =====
// Top level of the learning switch forwarder: request checks, control FSM,
// forwarding decision, configuration register and result register.
// Depends on lsf_pkg and lsf_table (which holds lsf_ram).
//
//   Channel   Direction  Handshake                 Contents
//   in        request    i_in_valid / o_in_stall    ingress port, length, dst and src MAC
//   out       result     o_out_valid / i_out_stall  egress mask, status, dst known, learned
//   cfg       write      i_cfg_wr_en                active port count
//
// On a forwarded request the table is swept one entry per cycle through the
// single read port of the entry RAM, comparing source and destination in the
// same pass, followed by the registered RAM read, a capture register and the
// decision/write-back state. A dropped request skips the sweep.
// There is no clearing pass: valid bits in flip-flops are cleared by the
// synchronous reset. One request is in flight at a time, and the next one is
// taken while the previous result still waits in the output register; the
// final decision cycle waits only if that register is full and stalled.

module learning_switch_forwarder
    import lsf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [ACT_W-1:0]  i_cfg_wr_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [PORT_W-1:0] i_ingress_port,
    input  logic [LEN_W-1:0]  i_frame_length,
    input  logic [MAC_W-1:0]  i_dst_mac,
    input  logic [MAC_W-1:0]  i_src_mac,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [MASK_W-1:0] o_egress_mask,
    output logic [1:0]        o_status,
    output logic              o_dst_known,
    output logic              o_learned_new
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [ACT_W-1:0]  r_active;
    logic [PORT_W-1:0] r_ingress;
    logic [MAC_W-1:0]  r_dst;
    logic [MAC_W-1:0]  r_src;
    t_status           r_status;
    logic              r_out_vld;
    logic [MASK_W-1:0] r_out_mask;
    t_status           r_out_status;
    logic              r_out_known;
    logic              r_out_learned;

    t_scan_cmd         scan_cmd;
    t_scan_res         scan_res;
    t_tbl_wr           tbl_wr;
    logic [IDX_W-1:0]  replace_ptr;

    logic [ACT_W-1:0]  in_count;
    t_status           in_status;
    logic              accept;
    logic              out_free;
    logic              finish;
    logic              fwd;
    logic              learn_upd;
    logic              learn_new;
    logic              dst_ok;
    logic [ACT_W-1:0]  cur_count;
    logic [MASK_W-1:0] flood_mask;
    logic [MASK_W-1:0] n_mask;

    // Checks on the incoming request, in priority order: ingress port first,
    // then the runt length, then a source equal to the destination.
    assign in_count = port_count(r_active);

    always_comb begin
        if ({1'b0, i_ingress_port} >= in_count) begin
            in_status = ST_BAD_PORT;
        end else if (i_frame_length < MIN_HEADER_BYTES) begin
            in_status = ST_SHORT;
        end else if (i_src_mac == i_dst_mac) begin
            in_status = ST_SAME;
        end else begin
            in_status = ST_FWD;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);

    // The sweep starts in the same edge that takes the request; the key
    // registers below hold the MACs steady for the whole sweep.
    assign scan_cmd.start   = accept && (in_status == ST_FWD);
    assign scan_cmd.src_mac = r_src;
    assign scan_cmd.dst_mac = r_dst;

    lsf_table u_table (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (scan_cmd),
        .i_wr          (tbl_wr),
        .o_res         (scan_res),
        .o_replace_ptr (replace_ptr)
    );

    // Decision cycle. The table is only written here, after the sweep has
    // finished, so a read and a write of the same entry never overlap.
    assign out_free  = !r_out_vld || !i_out_stall;
    assign finish    = (r_state == S_DONE) && out_free;
    assign fwd       = (r_status == ST_FWD);
    assign learn_upd = fwd && !r_src[GROUP_BIT_POS] && scan_res.src_hit;
    assign learn_new = fwd && !r_src[GROUP_BIT_POS] && !scan_res.src_hit;

    // The lookup takes effect after learning: a destination whose slot is
    // being replaced by the new source is no longer known and is flooded.
    assign dst_ok = fwd && !r_dst[GROUP_BIT_POS] && scan_res.dst_hit
                    && !(learn_new && (scan_res.dst_idx == replace_ptr));

    assign tbl_wr.en        = finish && (learn_upd || learn_new);
    assign tbl_wr.set_valid = learn_new;
    assign tbl_wr.idx       = scan_res.src_hit ? scan_res.src_idx : replace_ptr;
    assign tbl_wr.mac       = r_src;
    assign tbl_wr.port      = r_ingress;

    assign cur_count = port_count(r_active);

    // Flood goes to every active port except the one the frame came in on.
    always_comb begin
        for (int p = 0; p < MASK_W; p++) begin
            flood_mask[p] = (ACT_W'(p) < cur_count) && (PORT_W'(p) != r_ingress);
        end
    end

    // A known destination behind the ingress port or an inactive port is
    // filtered: nothing goes out, but the destination still counts as known.
    always_comb begin
        if (!fwd) begin
            n_mask = '0;
        end else if (dst_ok) begin
            if (({1'b0, scan_res.dst_port} < cur_count) && (scan_res.dst_port != r_ingress)) begin
                n_mask = MASK_W'(1) << scan_res.dst_port;
            end else begin
                n_mask = '0;
            end
        end else begin
            n_mask = flood_mask;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (in_status == ST_FWD) ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                if (scan_res.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_active  <= ACTIVE_RESET;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_active <= i_cfg_wr_data;
            end
            if (finish) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ingress <= i_ingress_port;
            r_dst     <= i_dst_mac;
            r_src     <= i_src_mac;
            r_status  <= in_status;
        end
        if (finish) begin
            r_out_mask    <= n_mask;
            r_out_status  <= r_status;
            r_out_known   <= dst_ok;
            r_out_learned <= learn_new;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_egress_mask = r_out_mask;
    assign o_status      = r_out_status;
    assign o_dst_known   = r_out_known;
    assign o_learned_new = r_out_learned;

endmodule

// ===== rtl/lsf_checker.sv =====
// Port-level checker for the learning switch forwarder, bound to the top level.
// Depends on lsf_pkg and learning_switch_forwarder.
module lsf_checker
    import lsf_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [MASK_W-1:0] o_egress_mask,
    input logic [1:0]        o_status,
    input logic              o_dst_known,
    input logic              o_learned_new
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // Every accepted request makes the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request accepted back to back");

    // A dropped frame carries no mask, no lookup hit and no learning.
    a_drop_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_FWD) |->
            (o_egress_mask == '0) && !o_dst_known && !o_learned_new)
        else $error("dropped frame with nonzero result fields");

    // A known destination goes to one port at most.
    a_known_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_dst_known |-> $onehot0(o_egress_mask))
        else $error("known destination sent to several ports");

endmodule

bind learning_switch_forwarder lsf_checker u_lsf_checker (.*);
